// File: rtl/gdo_pkg.sv
// Package for the Gregorian date offset block: widths, status codes, step types, month table.
package gdo_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int OFF_W  = 16;
  localparam int C100_W = 7;   // year mod 100
  localparam int Q100_W = 8;   // year div 100, year below 16384

  // Reciprocal of 100 scaled by 2^20, exact for every 14-bit year
  localparam int RECIP_100  = 10486;
  localparam int RECIP_SH   = 20;
  localparam int PROD_W     = 2 * YEAR_W;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_UNDER   = 2'd2,
    ST_OVER    = 2'd3
  } status_t;

  // Working date held between steps of the shared month stepper
  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [C100_W-1:0] c100;   // year mod 100
    logic [1:0]        q4;     // (year div 100) mod 4
    logic [OFF_W-1:0]  rem;    // days still to move
    logic              sub;    // 1: move backward
  } step_t;

  typedef struct packed {
    logic fin;   // remaining days fit in this month
    logic ovf;   // would step past December of the last year
    logic unf;   // would step before January of the first year
  } step_flags_t;

  // Length of a month; codes outside 1..12 read as zero
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    begin
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
        4'd2: len = leap ? 5'd29 : 5'd28;
        default: len = 5'd0;
      endcase
      return len;
    end
  endfunction

endpackage

// File: rtl/gdo_step_unit.sv
// Shared month stepper: moves the working date by one month boundary or finishes it.
module gdo_step_unit #(
  parameter int MIN_YEAR = 1900,
  parameter int MAX_YEAR = 9999
) (
  input  gdo_pkg::step_t       cur,
  output gdo_pkg::step_t       nxt,
  output gdo_pkg::step_flags_t flags
);
  import gdo_pkg::*;

  localparam logic [YEAR_W-1:0] YMIN = YEAR_W'(MIN_YEAR);
  localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(MAX_YEAR);

  logic             leap;
  logic [DAY_W-1:0] len_cur;
  logic [DAY_W-1:0] len_prev;
  logic [DAY_W-1:0] room;
  logic [MON_W-1:0] m_prev;
  logic [OFF_W-1:0] room_ext;
  logic [OFF_W-1:0] day_ext;

  // Leap year from tracked residues
  always_comb begin
    leap     = (cur.c100 == '0) ? (cur.q4 == 2'd0) : (cur.year[1:0] == 2'b00);
    len_cur  = month_len(cur.month, leap);
    m_prev   = (cur.month == 4'd1) ? 4'd12 : cur.month - 4'd1;
    len_prev = month_len(m_prev, leap);
    room     = len_cur - cur.day;
    room_ext = OFF_W'(room);
    day_ext  = OFF_W'(cur.day);
  end

  // One step forward or backward
  always_comb begin
    nxt   = cur;
    flags = '0;
    if (!cur.sub) begin
      if (cur.rem <= room_ext) begin
        flags.fin = 1'b1;
        nxt.day   = cur.day + cur.rem[DAY_W-1:0];
        nxt.rem   = '0;
      end else begin
        nxt.rem = cur.rem - room_ext - OFF_W'(1);
        nxt.day = DAY_W'(1);
        if (cur.month == 4'd12) begin
          flags.ovf = (cur.year == YMAX);
          nxt.month = 4'd1;
          nxt.year  = cur.year + YEAR_W'(1);
          if (cur.c100 == C100_W'(99)) begin
            nxt.c100 = '0;
            nxt.q4   = cur.q4 + 2'd1;
          end else begin
            nxt.c100 = cur.c100 + C100_W'(1);
          end
        end else begin
          nxt.month = cur.month + 4'd1;
        end
      end
    end else begin
      if (cur.rem < day_ext) begin
        flags.fin = 1'b1;
        nxt.day   = cur.day - cur.rem[DAY_W-1:0];
        nxt.rem   = '0;
      end else begin
        nxt.rem   = cur.rem - day_ext;
        nxt.month = m_prev;
        nxt.day   = len_prev;
        if (cur.month == 4'd1) begin
          flags.unf = (cur.year == YMIN);
          nxt.year  = cur.year - YEAR_W'(1);
          if (cur.c100 == '0) begin
            nxt.c100 = C100_W'(99);
            nxt.q4   = cur.q4 - 2'd1;
          end else begin
            nxt.c100 = cur.c100 - C100_W'(1);
          end
        end
      end
    end
  end

endmodule

// File: rtl/gregorian_date_offset.sv
// Top level of the Gregorian date offset block: request sequencer around the month stepper.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_ready | req_type, in_day, in_month, in_year, offset_days
//  out     | out_valid/out_ready | out_day, out_month, out_year, status
//
// A request passes PREP and CHECK, then STEP once per month boundary crossed, then DONE;
// the single month stepper crosses one boundary per cycle.
// Synchronous reset returns the sequencer to idle and drops out_valid.
// One output register holds the result; a new request is taken while it waits,
// and a finished request waits in DONE until the output register is free.
module gregorian_date_offset #(
  parameter int MIN_YEAR    = 1900,
  parameter int MAX_YEAR    = 9999,
  parameter int OFFSET_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [gdo_pkg::DAY_W-1:0]   in_day,
  input  logic [gdo_pkg::MON_W-1:0]   in_month,
  input  logic [gdo_pkg::YEAR_W-1:0]  in_year,
  input  logic [gdo_pkg::OFF_W-1:0]   offset_days,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gdo_pkg::DAY_W-1:0]   out_day,
  output logic [gdo_pkg::MON_W-1:0]   out_month,
  output logic [gdo_pkg::YEAR_W-1:0]  out_year,
  output logic [1:0]                  status
);
  import gdo_pkg::*;

  localparam logic [YEAR_W-1:0] YMIN = YEAR_W'(MIN_YEAR);
  localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(MAX_YEAR);
  localparam logic [OFF_W-1:0]  OFF_MASK =
    (OFFSET_BITS >= OFF_W) ? {OFF_W{1'b1}} : OFF_W'((1 << OFFSET_BITS) - 1);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_CHECK, S_STEP, S_DONE} state_t;

  state_t           state;
  step_t            cur;
  step_t            nxt;
  step_flags_t      flags;
  logic [Q100_W-1:0] q100;
  logic [DAY_W-1:0]  res_day;
  logic [MON_W-1:0]  res_month;
  logic [YEAR_W-1:0] res_year;
  status_t           res_status;

  logic [PROD_W-1:0] prod;
  logic [YEAR_W-1:0] hundreds;
  logic [YEAR_W-1:0] ymod;
  logic [C100_W-1:0] c100_init;
  logic              leap_init;
  logic [DAY_W-1:0]  len_init;
  logic              date_ok;
  logic              out_free;

  gdo_step_unit #(
    .MIN_YEAR(MIN_YEAR),
    .MAX_YEAR(MAX_YEAR)
  ) u_step (
    .cur  (cur),
    .nxt  (nxt),
    .flags(flags)
  );

  // Year div 100 by reciprocal multiply
  assign prod = PROD_W'(cur.year) * PROD_W'(RECIP_100);

  // Year mod 100, leap year and date check
  always_comb begin
    hundreds  = YEAR_W'(q100) * YEAR_W'(100);
    ymod      = cur.year - hundreds;
    c100_init = ymod[C100_W-1:0];
    leap_init = (c100_init == '0) ? (q100[1:0] == 2'd0) : (cur.year[1:0] == 2'b00);
    len_init  = month_len(cur.month, leap_init);
    date_ok   = (cur.year >= YMIN) && (cur.year <= YMAX) &&
                (cur.month >= 4'd1) && (cur.month <= 4'd12) &&
                (cur.day >= DAY_W'(1)) && (cur.day <= len_init);
  end

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Sequencer, working date and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // DONE refills the output register itself when it is free
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur.day   <= in_day;
            cur.month <= in_month;
            cur.year  <= in_year;
            cur.rem   <= offset_days & OFF_MASK;
            cur.sub   <= req_type;
            cur.c100  <= '0;
            cur.q4    <= '0;
            state     <= S_PREP;
          end
        end
        S_PREP: begin
          q100  <= prod[RECIP_SH +: Q100_W];
          state <= S_CHECK;
        end
        S_CHECK: begin
          cur.c100 <= c100_init;
          cur.q4   <= q100[1:0];
          if (date_ok) begin
            state <= S_STEP;
          end else begin
            res_day    <= DAY_W'(1);
            res_month  <= MON_W'(1);
            res_year   <= YMIN;
            res_status <= ST_INVALID;
            state      <= S_DONE;
          end
        end
        S_STEP: begin
          if (flags.fin) begin
            res_day    <= nxt.day;
            res_month  <= nxt.month;
            res_year   <= nxt.year;
            res_status <= ST_OK;
            state      <= S_DONE;
          end else if (flags.ovf) begin
            res_day    <= DAY_W'(31);
            res_month  <= MON_W'(12);
            res_year   <= YMAX;
            res_status <= ST_OVER;
            state      <= S_DONE;
          end else if (flags.unf) begin
            res_day    <= DAY_W'(1);
            res_month  <= MON_W'(1);
            res_year   <= YMIN;
            res_status <= ST_UNDER;
            state      <= S_DONE;
          end else begin
            cur <= nxt;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_day   <= res_day;
            out_month <= res_month;
            out_year  <= res_year;
            status    <= res_status;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/gdo_checker.sv
// Port-level checker for the Gregorian date offset block, bound to the top level.
module gdo_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gdo_pkg::DAY_W-1:0]   out_day,
  input logic [gdo_pkg::MON_W-1:0]   out_month,
  input logic [gdo_pkg::YEAR_W-1:0]  out_year,
  input logic [1:0]                  status
);
  import gdo_pkg::*;

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_day) && $stable(out_month) &&
                                $stable(out_year) && $stable(status))
    else $error("result changed while stalled");

  // One request at a time: busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // Results carry a real calendar month and day
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_month >= 4'd1 && out_month <= 4'd12 &&
                  out_day >= 5'd1 && out_day <= 5'd31)
    else $error("result date out of range");

  // Invalid, underflow and overflow results are the fixed clamp dates
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INVALID || status == ST_UNDER) |->
      out_day == 5'd1 && out_month == 4'd1)
    else $error("clamped result is not the first of January");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OVER |-> out_day == 5'd31 && out_month == 4'd12)
    else $error("saturated result is not the last of December");

endmodule

bind gregorian_date_offset gdo_checker u_gdo_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_day  (out_day),
  .out_month(out_month),
  .out_year (out_year),
  .status   (status)
);

// File: tb/sv/gregorian_date_offset_checker.sv
// Checker for the Gregorian date offset block: predicts each shifted date and compares results.
module gregorian_date_offset_checker #(
  parameter int MIN_YEAR    = 1900,
  parameter int MAX_YEAR    = 9999,
  parameter int OFFSET_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       req_type,
  input  logic [gdo_pkg::DAY_W-1:0]  in_day,
  input  logic [gdo_pkg::MON_W-1:0]  in_month,
  input  logic [gdo_pkg::YEAR_W-1:0] in_year,
  input  logic [gdo_pkg::OFF_W-1:0]  offset_days,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [gdo_pkg::DAY_W-1:0]  out_day,
  input  logic [gdo_pkg::MON_W-1:0]  out_month,
  input  logic [gdo_pkg::YEAR_W-1:0] out_year,
  input  logic [1:0]                 status,
  output int                         fail_count,
  output int                         pending,
  output int                         n_shifted,
  output int                         n_invalid,
  output int                         n_clamped
);
  timeunit 1ns;
  timeprecision 1ps;
  import gdo_pkg::*;

  typedef struct {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    status_t           st;
  } shifted_date_t;

  shifted_date_t expected_dates[$];
  int errs;
  int shifted_cnt;
  int invalid_cnt;
  int clamped_cnt;
  int result_idx;

  assign fail_count = errs;
  assign pending    = expected_dates.size();
  assign n_shifted  = shifted_cnt;
  assign n_invalid  = invalid_cnt;
  assign n_clamped  = clamped_cnt;

  // Leap rule: every 400 years, or every 4 years except centuries
  function automatic bit leap_year(int y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int days_in_month(int m, int y);
    int len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11: len = 30;
      2: len = leap_year(y) ? 29 : 28;
      default: len = 0;
    endcase
    return len;
  endfunction

  // Days counted from 1 March of year 0
  function automatic longint day_index(int d, int m, int y);
    longint yy, era, yoe, mi, doy, doe;
    yy  = y - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mi  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mi + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe;
  endfunction

  // Back from a day index to day, month, year
  function automatic void index_to_date(input longint z, output int d, output int m,
                                        output int y);
    longint era, doe, yoe, yy, doy, mp, mm;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    yy  = yoe + era * 400;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = int'(doy - (153 * mp + 2) / 5 + 1);
    mm  = (mp < 10) ? mp + 3 : mp - 9;
    if (mm <= 2) yy = yy + 1;
    m = int'(mm);
    y = int'(yy);
  endfunction

  function automatic shifted_date_t shift_date(logic sub, logic [DAY_W-1:0] d,
                                               logic [MON_W-1:0] m, logic [YEAR_W-1:0] y,
                                               logic [OFF_W-1:0] off);
    shifted_date_t r;
    longint span, lo, hi, z;
    int di, mi, yi, rd, rm, ry;
    di = int'(d);
    mi = int'(m);
    yi = int'(y);
    span = longint'(off) & ((longint'(1) << OFFSET_BITS) - 1);
    r.day   = DAY_W'(1);
    r.month = MON_W'(1);
    r.year  = YEAR_W'(MIN_YEAR);
    // Date check: year range, month range, day within the month
    if (yi < MIN_YEAR || yi > MAX_YEAR || mi < 1 || mi > 12 ||
        di < 1 || di > days_in_month(mi, yi)) begin
      r.st = ST_INVALID;
      return r;
    end
    lo = day_index(1, 1, MIN_YEAR);
    hi = day_index(31, 12, MAX_YEAR);
    z  = day_index(di, mi, yi);
    z  = sub ? z - span : z + span;
    if (z < lo) begin
      r.st = ST_UNDER;
    end else if (z > hi) begin
      r.day   = DAY_W'(31);
      r.month = MON_W'(12);
      r.year  = YEAR_W'(MAX_YEAR);
      r.st    = ST_OVER;
    end else begin
      index_to_date(z, rd, rm, ry);
      r.day   = DAY_W'(rd);
      r.month = MON_W'(rm);
      r.year  = YEAR_W'(ry);
      r.st    = ST_OK;
    end
    return r;
  endfunction

  initial begin
    errs        = 0;
    shifted_cnt = 0;
    invalid_cnt = 0;
    clamped_cnt = 0;
    result_idx  = 0;
  end

  // Compare results first, then record the request taken on the same edge
  always @(posedge clk) begin
    shifted_date_t exp_r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          $error("result %0d arrived with no request pending", result_idx);
          errs++;
        end else begin
          exp_r = expected_dates.pop_front();
          if (out_day !== exp_r.day) begin
            $error("result %0d out_day: expected %0d, actual %0d", result_idx, exp_r.day,
                   out_day);
            errs++;
          end
          if (out_month !== exp_r.month) begin
            $error("result %0d out_month: expected %0d, actual %0d", result_idx,
                   exp_r.month, out_month);
            errs++;
          end
          if (out_year !== exp_r.year) begin
            $error("result %0d out_year: expected %0d, actual %0d", result_idx, exp_r.year,
                   out_year);
            errs++;
          end
          if (status !== 2'(exp_r.st)) begin
            $error("result %0d status: expected %0d, actual %0d", result_idx,
                   2'(exp_r.st), status);
            errs++;
          end
          case (exp_r.st)
            ST_OK:      shifted_cnt++;
            ST_INVALID: invalid_cnt++;
            default:    clamped_cnt++;
          endcase
        end
        result_idx++;
      end
      if (in_valid && in_ready)
        expected_dates.push_back(shift_date(req_type, in_day, in_month, in_year,
                                            offset_days));
    end
  end

endmodule

// File: tb/sv/gregorian_date_offset_tb.sv
// Testbench top for the Gregorian date offset block: clock, reset, request stimulus, verdict.
module gregorian_date_offset_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MIN_YEAR     = 1900;
  localparam int MAX_YEAR     = 9999;
  localparam int OFFSET_BITS  = 16;
  localparam int RANDOM_REQS  = 250;
  localparam int PRESSURE_AT  = 60;
  localparam int PRESSURE_LEN = 700;
  localparam int DRAIN_CYCLES = 20;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic                        req_type;
  logic [gdo_pkg::DAY_W-1:0]   in_day;
  logic [gdo_pkg::MON_W-1:0]   in_month;
  logic [gdo_pkg::YEAR_W-1:0]  in_year;
  logic [gdo_pkg::OFF_W-1:0]   offset_days;
  logic                        out_valid;
  logic                        out_ready;
  logic [gdo_pkg::DAY_W-1:0]   out_day;
  logic [gdo_pkg::MON_W-1:0]   out_month;
  logic [gdo_pkg::YEAR_W-1:0]  out_year;
  logic [1:0]                  status;

  int fail_count;
  int pending;
  int n_shifted;
  int n_invalid;
  int n_clamped;
  int sent;
  bit tx_calm;
  bit rx_calm;

  gregorian_date_offset #(
    .MIN_YEAR(MIN_YEAR), .MAX_YEAR(MAX_YEAR), .OFFSET_BITS(OFFSET_BITS)
  ) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .in_day(in_day), .in_month(in_month), .in_year(in_year),
    .offset_days(offset_days),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_day(out_day), .out_month(out_month), .out_year(out_year), .status(status)
  );

  gregorian_date_offset_checker #(
    .MIN_YEAR(MIN_YEAR), .MAX_YEAR(MAX_YEAR), .OFFSET_BITS(OFFSET_BITS)
  ) u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .in_day(in_day), .in_month(in_month), .in_year(in_year),
    .offset_days(offset_days),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_day(out_day), .out_month(out_month), .out_year(out_year), .status(status),
    .fail_count(fail_count), .pending(pending),
    .n_shifted(n_shifted), .n_invalid(n_invalid), .n_clamped(n_clamped)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Idle length: mostly short, a few long, none while calm
  function automatic int idle_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offer one request, hold it until taken, then idle for a while
  task automatic send_req(logic t, int d, int m, int y, int off);
    int gap;
    in_valid    <= 1'b1;
    req_type    <= t;
    in_day      <= d[gdo_pkg::DAY_W-1:0];
    in_month    <= m[gdo_pkg::MON_W-1:0];
    in_year     <= y[gdo_pkg::YEAR_W-1:0];
    offset_days <= off[gdo_pkg::OFF_W-1:0];
    do @(posedge clk); while (!in_ready);
    sent++;
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    gap = idle_len(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Request source: directed corners, then random dates and offsets
  initial begin
    int r, d, m, y, off;
    logic t;
    sent        = 0;
    tx_calm     = 1'b0;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    req_type    <= 1'b0;
    in_day      <= '0;
    in_month    <= '0;
    in_year     <= '0;
    offset_days <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (rst);

    // zero offset, malformed dates, leap corners
    send_req(1'b0, 15, 6, 2000, 0);
    send_req(1'b0, 0, 6, 2000, 10);
    send_req(1'b1, 31, 4, 2001, 10);
    send_req(1'b0, 29, 2, 1900, 1);
    send_req(1'b0, 29, 2, 2000, 1);
    send_req(1'b1, 29, 2, 2024, 366);
    send_req(1'b0, 30, 2, 2024, 1);
    send_req(1'b0, 10, 0, 2010, 5);
    send_req(1'b0, 10, 13, 2010, 5);
    send_req(1'b1, 31, 15, 9999, 65535);
    send_req(1'b0, 1, 1, 1899, 0);
    send_req(1'b0, 1, 1, 0, 0);
    // lower edge of the date range
    send_req(1'b1, 1, 1, 1900, 0);
    send_req(1'b1, 2, 1, 1900, 1);
    send_req(1'b1, 1, 1, 1900, 1);
    send_req(1'b1, 10, 3, 1950, 65535);
    // upper edge of the date range
    send_req(1'b0, 31, 12, 9999, 0);
    send_req(1'b0, 30, 12, 9999, 1);
    send_req(1'b0, 31, 12, 9999, 1);
    send_req(1'b0, 1, 1, 9900, 65535);
    // widest in-range moves
    send_req(1'b0, 1, 1, 1900, 65535);
    send_req(1'b1, 31, 12, 9999, 65535);

    repeat (RANDOM_REQS) begin
      r = $urandom_range(0, 99);
      t = 1'($urandom_range(0, 1));
      if (r < 25) begin
        // noise: any field value
        d = $urandom_range(0, 31);
        m = $urandom_range(0, 15);
        y = $urandom_range(0, 9999);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) y = $urandom_range(MIN_YEAR, MIN_YEAR + 3);
        else if (r < 30) y = $urandom_range(MAX_YEAR - 3, MAX_YEAR);
        else y = $urandom_range(MIN_YEAR, MAX_YEAR);
        m = $urandom_range(1, 12);
        d = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 28) : $urandom_range(28, 31);
      end
      r = $urandom_range(0, 99);
      if (r < 70) off = $urandom_range(0, 800);
      else if (r < 90) off = $urandom_range(0, 8000);
      else off = $urandom_range(0, 65535);
      send_req(t, d, m, y, off);
    end
    in_valid <= 1'b0;

    // wait out every expected result, then let the block settle
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run sent %0d requests in both directions with idle gaps and an output stall.",
             sent);
    $display("Results: %0d shifted in range, %0d invalid dates, %0d clamped at the limits.",
             n_shifted, n_invalid, n_clamped);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result sink: random holds, one long hold to back the block up
  initial begin
    int hold;
    int taken;
    taken     = 0;
    rx_calm   = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = (taken == PRESSURE_AT) ? PRESSURE_LEN : idle_len(rx_calm);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #12000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/gdo_pkg.sv
rtl/gdo_step_unit.sv
rtl/gregorian_date_offset.sv
rtl/gdo_checker.sv
tb/sv/gregorian_date_offset_checker.sv
tb/sv/gregorian_date_offset_tb.sv
